@@ design/nbt_pkg.sv @@
package nbt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int CHANCE_BITS = 8;
    localparam int CLASS_COUNT = 4;
    localparam int ADDR_W      = 48;
    localparam int CHANCE_W    = 8;
    localparam int COUNT_W     = 5;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CLS_W       = 2;
    localparam int PROD_W      = CHANCE_BITS + COUNT_W;

    localparam logic [CLS_W-1:0] CLS_FRAMES_ONLY = 2'd0;
    localparam logic [CLS_W-1:0] CLS_HOP_FRAMES  = 2'd1;
    localparam logic [CLS_W-1:0] CLS_HOP_ONLY    = 2'd2;
    localparam logic [CLS_W-1:0] CLS_REST        = 2'd3;

    typedef enum logic [1:0] {
        KIND_UPDATE = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_SELECT = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_ABSENT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_SHIFT,
        ST_COUNT,
        ST_PICK,
        ST_DONE
    } state_t;

    typedef struct packed {
        kind_t                kind;
        logic [ADDR_W-1:0]    node_address;
        logic                 next_hop_flag;
        logic                 frames_flag;
        logic [CHANCE_W-1:0]  chance;
    } in_beat_t;

    typedef struct packed {
        logic [ADDR_W-1:0]    picked_address;
        logic                 is_broadcast;
        status_t              status;
        logic [COUNT_W-1:0]   entry_count;
    } out_beat_t;

    typedef struct packed {
        logic [ADDR_W-1:0]    address;
        logic                 next_hop;
        logic                 frames;
    } entry_t;

    typedef struct packed {
        logic                 rd_en;
        logic [IDX_W-1:0]     rd_addr;
        logic                 wr_en;
        logic [IDX_W-1:0]     wr_addr;
        entry_t               wr_data;
    } mem_req_t;

    typedef struct packed {
        logic                 valid;
        out_beat_t            beat;
    } res_t;

    function automatic logic [CLS_W-1:0] class_of(entry_t e);
        logic [CLS_W-1:0] cls;
        case ({e.next_hop, e.frames})
            2'b01:   cls = CLS_FRAMES_ONLY;
            2'b11:   cls = CLS_HOP_FRAMES;
            2'b10:   cls = CLS_HOP_ONLY;
            default: cls = CLS_REST;
        endcase
        return cls;
    endfunction

endpackage

@@ design/neighbor_table_priority_select_unit.sv @@
// Neighbor table with priority select.
// Input channel item/item_valid/item_stall carries one command beat: update or
// insert, delete, select or clear. Output channel result/result_valid/
// result_stall returns exactly one beat per command, in command order.
// The table lives in a single-port-read, single-port-write synchronous RAM
// with a registered read port; each command is run by a sequencer that
// streams entries out of it one per cycle.
// Steps per command, with n valid entries: clear only resets the count; update
// searches up to n entries (less on an early match); delete searches, then
// shifts the later entries down; select runs a counting pass over all entries,
// then a picking pass that stops at the chosen entry.
// One command is in work at a time; item_stall is high from accept until the
// result beat moves into the output register. The next command is taken while
// that output beat still waits on result_stall.
// Reset empties the table and the output register; entry contents are not
// cleared. A stalled result holds until taken, and a finished command waits
// inside the block while the output register is full and stalled.
module neighbor_table_priority_select_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  nbt_pkg::in_beat_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output nbt_pkg::out_beat_t result
);
    import nbt_pkg::*;

    mem_req_t  mem_req;
    entry_t    rd_data;
    res_t      res;
    logic      take;
    logic      out_valid_reg, out_valid_next;
    out_beat_t out_reg, out_next;

    nbt_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    nbt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .take       (take),
        .res        (res),
        .mem_req    (mem_req),
        .rd_data    (rd_data)
    );

    assign take = res.valid && (!out_valid_reg || !result_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            out_next       = res.beat;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ design/nbt_mem.sv @@
module nbt_mem (
    input  logic              clk,
    input  nbt_pkg::mem_req_t req,
    output nbt_pkg::entry_t   rd_data
);
    import nbt_pkg::*;

    entry_t mem_reg [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_reg[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem_reg[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/nbt_ctrl.sv @@
module nbt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  nbt_pkg::in_beat_t item,
    input  logic              take,
    output nbt_pkg::res_t     res,
    output nbt_pkg::mem_req_t mem_req,
    input  nbt_pkg::entry_t   rd_data
);
    import nbt_pkg::*;

    state_t               state_reg, state_next;
    in_beat_t             cmd_reg, cmd_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0]   issue_reg, issue_next;
    logic                 dv_reg, dv_next;
    logic [COUNT_W-1:0]   didx_reg, didx_next;
    logic [COUNT_W-1:0]   cnt_reg [CLASS_COUNT];
    logic [COUNT_W-1:0]   cnt_next [CLASS_COUNT];
    logic [CLS_W-1:0]     sel_cls_reg, sel_cls_next;
    logic [COUNT_W-1:0]   target_reg, target_next;
    logic [COUNT_W-1:0]   seen_reg, seen_next;
    logic [ADDR_W-1:0]    picked_reg, picked_next;
    logic                 bcast_reg, bcast_next;
    status_t              status_reg, status_next;

    logic                 accept;
    logic                 issue_more;
    logic                 scan_end;
    logic                 hit;
    logic [CLS_W-1:0]     rd_cls;
    logic                 pick_hit;
    logic                 any_cls;
    logic [CLS_W-1:0]     first_cls;
    logic [COUNT_W-1:0]   first_n;
    logic [PROD_W-1:0]    product;
    logic [COUNT_W-1:0]   didx_m1;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != ST_IDLE);
    assign issue_more = (issue_reg < count_reg);
    assign scan_end   = !dv_reg && !issue_more;
    assign hit        = dv_reg && (rd_data.address == cmd_reg.node_address);
    assign rd_cls     = class_of(rd_data);
    assign pick_hit   = dv_reg && (rd_cls == sel_cls_reg) && (seen_reg == target_reg);
    assign didx_m1    = didx_reg - COUNT_W'(1);
    assign product    = PROD_W'(cmd_reg.chance[CHANCE_BITS-1:0]) * PROD_W'(first_n);

    always_comb
    begin
        any_cls   = 1'b0;
        first_cls = CLS_REST;
        first_n   = '0;
        for (int i = CLASS_COUNT - 1; i >= 0; i--)
        begin
            if (cnt_reg[i] != '0)
            begin
                any_cls   = 1'b1;
                first_cls = CLS_W'(i);
                first_n   = cnt_reg[i];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.kind)
                        KIND_UPDATE: state_next = ST_FIND;
                        KIND_DELETE: state_next = ST_FIND;
                        KIND_SELECT: state_next = ST_COUNT;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_FIND:
            begin
                if (hit)
                begin
                    state_next = (cmd_reg.kind == KIND_DELETE) ? ST_SHIFT : ST_DONE;
                end
                else if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT:
            begin
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_COUNT:
            begin
                if (scan_end)
                begin
                    state_next = any_cls ? ST_PICK : ST_DONE;
                end
            end
            ST_PICK:
            begin
                if (pick_hit || scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next     = cmd_reg;
        count_next   = count_reg;
        issue_next   = issue_reg;
        dv_next      = 1'b0;
        didx_next    = issue_reg;
        cnt_next     = cnt_reg;
        sel_cls_next = sel_cls_reg;
        target_next  = target_reg;
        seen_next    = seen_reg;
        picked_next  = picked_reg;
        bcast_next   = bcast_reg;
        status_next  = status_reg;

        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = issue_reg[IDX_W-1:0];
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = didx_reg[IDX_W-1:0];
        mem_req.wr_data = rd_data;

        if ((state_reg == ST_FIND || state_reg == ST_SHIFT || state_reg == ST_COUNT
             || state_reg == ST_PICK) && issue_more)
        begin
            mem_req.rd_en = 1'b1;
            issue_next    = issue_reg + COUNT_W'(1);
            dv_next       = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = item;
                    issue_next  = '0;
                    seen_next   = '0;
                    picked_next = '0;
                    bcast_next  = 1'b0;
                    status_next = STATUS_OK;
                    for (int i = 0; i < CLASS_COUNT; i++)
                    begin
                        cnt_next[i] = '0;
                    end
                    if (item.kind == KIND_CLEAR)
                    begin
                        count_next = '0;
                    end
                end
            end
            ST_FIND:
            begin
                if (hit)
                begin
                    if (cmd_reg.kind == KIND_DELETE)
                    begin
                        issue_next = didx_reg + COUNT_W'(1);
                        dv_next    = 1'b0;
                    end
                    else
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_data = '{cmd_reg.node_address, cmd_reg.next_hop_flag,
                                            cmd_reg.frames_flag};
                    end
                end
                else if (scan_end)
                begin
                    if (cmd_reg.kind == KIND_DELETE)
                    begin
                        status_next = STATUS_ABSENT;
                    end
                    else if (count_reg < COUNT_W'(TABLE_DEPTH))
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = count_reg[IDX_W-1:0];
                        mem_req.wr_data = '{cmd_reg.node_address, cmd_reg.next_hop_flag,
                                            cmd_reg.frames_flag};
                        count_next      = count_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        status_next = STATUS_FULL;
                    end
                end
            end
            ST_SHIFT:
            begin
                if (dv_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = didx_m1[IDX_W-1:0];
                end
                if (scan_end)
                begin
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            ST_COUNT:
            begin
                if (dv_reg)
                begin
                    cnt_next[rd_cls] = cnt_reg[rd_cls] + COUNT_W'(1);
                end
                if (scan_end)
                begin
                    if (any_cls)
                    begin
                        sel_cls_next = first_cls;
                        target_next  = product[PROD_W-1:CHANCE_BITS];
                        issue_next   = '0;
                    end
                    else
                    begin
                        picked_next = '1;
                        bcast_next  = 1'b1;
                    end
                end
            end
            ST_PICK:
            begin
                if (dv_reg && rd_cls == sel_cls_reg)
                begin
                    if (seen_reg == target_reg)
                    begin
                        picked_next = rd_data.address;
                    end
                    else
                    begin
                        seen_next = seen_reg + COUNT_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.valid               = (state_reg == ST_DONE);
        res.beat.picked_address = picked_reg;
        res.beat.is_broadcast   = bcast_reg;
        res.beat.status         = status_reg;
        res.beat.entry_count    = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            dv_reg    <= 1'b0;
            issue_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            dv_reg    <= dv_next;
            issue_reg <= issue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        didx_reg    <= didx_next;
        cnt_reg     <= cnt_next;
        sel_cls_reg <= sel_cls_next;
        target_reg  <= target_next;
        seen_reg    <= seen_next;
        picked_reg  <= picked_next;
        bcast_reg   <= bcast_next;
        status_reg  <= status_next;
    end

endmodule
